@@ rtl/mpnp_pkg.sv @@
// Shared widths for the 2x2 pooling and nibble packing block.
package mpnp_pkg;
    localparam int PIX_W  = 8;
    localparam int NIB_W  = 4;
    localparam int CELL_W = 4 * NIB_W;
    localparam int IDX_W  = 7;

    typedef logic [CELL_W-1:0] t_cell;
endpackage

@@ rtl/map_pool_2x2_nibble_pack.sv @@
// Top level: 2x2 stride-2 pooling of a four-channel map into packed 16-bit cell words.
//
// Input channel (i_in_valid / o_in_ready) takes one pixel per beat in raster order over a
// (2*OUT_WIDTH) x (2*OUT_HEIGHT) frame; each byte is cut to its top nibble.
// Output channel (o_out_valid / i_out_ready) gives one cell word per 2x2 block, with its
// cell index and a last-cell flag, after the odd-row, odd-column pixel of that block.
// Even rows store the column-pair result in a line RAM of OUT_WIDTH words; on odd rows
// the read for a pair is issued on its even-column pixel, so the data is ready when the
// odd-column pixel arrives.
// A cell word is registered when its final pixel is accepted and is shown on the output in the cycle after.
// Throughput: one pixel per cycle, except that a cell-producing pixel waits on a stalled output.
// A stalled output holds its beat; pixels that produce no cell are still accepted, and a
// pixel that produces a cell is accepted as soon as the output slot frees or drains.
// Reset clears the column, row and cell counters and the output valid; the line RAM
// needs no clearing since every entry is written on an even row before it is read.
// After the last pixel of a frame the counters wrap and the next frame begins.
module map_pool_2x2_nibble_pack import mpnp_pkg::*; #(
    parameter int OUT_WIDTH  = 10,
    parameter int OUT_HEIGHT = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [PIX_W-1:0]  i_obstacle,
    input  logic [PIX_W-1:0]  i_range_inverse,
    input  logic [PIX_W-1:0]  i_uncertainty,
    input  logic [PIX_W-1:0]  i_gate_opening,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CELL_W-1:0] o_cell_word,
    output logic [IDX_W-1:0]  o_cell_index,
    output logic              o_last_cell
);
    localparam int IN_W   = 2 * OUT_WIDTH;
    localparam int IN_H   = 2 * OUT_HEIGHT;
    localparam int CW     = $clog2(IN_W);
    localparam int RW     = $clog2(IN_H);
    localparam int AW     = (OUT_WIDTH > 1) ? $clog2(OUT_WIDTH) : 1;
    localparam int CELLS  = OUT_WIDTH * OUT_HEIGHT;
    localparam int NW_RAW = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int NW     = (NW_RAW > IDX_W) ? NW_RAW : IDX_W;

    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [NW-1:0] r_cnt, n_cnt;
    t_cell         r_pair;
    t_cell         r_word;
    logic [IDX_W-1:0] r_idx;
    logic          r_last;
    logic          r_valid, n_valid;

    t_cell         px;
    t_cell         pair;
    t_cell         cell_word;
    t_cell         rd_data;
    logic [AW-1:0] ocol;
    logic          odd_col;
    logic          odd_row;
    logic          emit;
    logic          accept;
    logic          last_now;

    assign px = {i_gate_opening[PIX_W-1 -: NIB_W], i_uncertainty[PIX_W-1 -: NIB_W],
                 i_range_inverse[PIX_W-1 -: NIB_W], i_obstacle[PIX_W-1 -: NIB_W]};

    assign ocol    = AW'(r_col >> 1);
    assign odd_col = r_col[0];
    assign odd_row = r_row[0];
    assign emit    = odd_col && odd_row;

    assign o_in_ready = !emit || !r_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign last_now   = (r_cnt == NW'(CELLS - 1));

    mpnp_join u_join_pair (
        .i_a (r_pair),
        .i_b (px),
        .o_y (pair)
    );

    mpnp_join u_join_cell (
        .i_a (rd_data),
        .i_b (pair),
        .o_y (cell_word)
    );

    mpnp_ram #(
        .WIDTH (CELL_W),
        .DEPTH (OUT_WIDTH)
    ) u_line (
        .i_clk   (i_clk),
        .i_we    (accept && odd_col && !odd_row),
        .i_waddr (ocol),
        .i_wdata (pair),
        .i_re    (accept && !odd_col && odd_row),
        .i_raddr (ocol),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        n_cnt   = r_cnt;
        n_valid = r_valid && !i_out_ready;
        if (accept) begin
            if (r_col == CW'(IN_W - 1)) begin
                n_col = '0;
                n_row = (r_row == RW'(IN_H - 1)) ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
            if (emit) begin
                n_valid = 1'b1;
                n_cnt   = last_now ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && !odd_col) begin
            r_pair <= px;
        end
        if (accept && emit) begin
            r_word <= cell_word;
            r_idx  <= r_cnt[IDX_W-1:0];
            r_last <= last_now;
        end
    end

    assign o_out_valid  = r_valid;
    assign o_cell_word  = r_word;
    assign o_cell_index = r_idx;
    assign o_last_cell  = r_last;
endmodule

@@ rtl/mpnp_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module mpnp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ rtl/mpnp_join.sv @@
// Nibble-wise join of two packed words: max on the three low nibbles, min on the top one.
module mpnp_join import mpnp_pkg::*; (
    input  t_cell i_a,
    input  t_cell i_b,
    output t_cell o_y
);
    always_comb begin
        logic [NIB_W-1:0] na;
        logic [NIB_W-1:0] nb;
        o_y = '0;
        for (int k = 0; k < 4; k++) begin
            na = i_a[k*NIB_W +: NIB_W];
            nb = i_b[k*NIB_W +: NIB_W];
            if (k < 3) begin
                o_y[k*NIB_W +: NIB_W] = (na > nb) ? na : nb;
            end else begin
                o_y[k*NIB_W +: NIB_W] = (na < nb) ? na : nb;
            end
        end
    end
endmodule

@@ test/map_pool_2x2_nibble_pack_tb.sv @@
// Self-checking testbench for the 2x2 pooling and nibble packing block.
module map_pool_2x2_nibble_pack_tb;
    import mpnp_pkg::*;

    localparam int OUT_W       = 10;
    localparam int OUT_H       = 10;
    localparam int IN_W        = 2 * OUT_W;
    localparam int IN_H        = 2 * OUT_H;
    localparam int N_DIRECTED  = 24;
    localparam int N_PIXELS    = 1200;
    localparam int TAIL_PIXELS = 150;
    localparam int HOLD_AT     = 500;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [PIX_W-1:0] obstacle;
        logic [PIX_W-1:0] range_inv;
        logic [PIX_W-1:0] uncert;
        logic [PIX_W-1:0] gate;
    } pixel_t;

    typedef struct packed {
        t_cell            word;
        logic [IDX_W-1:0] index;
        logic             last;
    } cell_t;

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic              o_in_ready;
    logic [PIX_W-1:0]  i_obstacle      = '0;
    logic [PIX_W-1:0]  i_range_inverse = '0;
    logic [PIX_W-1:0]  i_uncertainty   = '0;
    logic [PIX_W-1:0]  i_gate_opening  = '0;
    logic              o_out_valid;
    logic              i_out_ready     = 1'b0;
    logic [CELL_W-1:0] o_cell_word;
    logic [IDX_W-1:0]  o_cell_index;
    logic              o_last_cell;

    map_pool_2x2_nibble_pack #(
        .OUT_WIDTH  (OUT_W),
        .OUT_HEIGHT (OUT_H)
    ) uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_obstacle      (i_obstacle),
        .i_range_inverse (i_range_inverse),
        .i_uncertainty   (i_uncertainty),
        .i_gate_opening  (i_gate_opening),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_cell_word     (o_cell_word),
        .o_cell_index    (o_cell_index),
        .o_last_cell     (o_last_cell)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    pixel_t pixels_pending[$];
    cell_t  cells_due[$];

    // pooling state mirror
    int     pix_col;
    int     pix_row;
    t_cell  pair_word;
    t_cell  line_store [OUT_W];

    int     pixels_in;
    int     cells_seen;
    int     cells_expected;
    int     mismatches;
    int     gap_left;
    int     stall_left;
    int     hold_left;
    int     quiet_cycles;
    logic   hold_done;
    logic   tail;
    logic   px_taken;
    pixel_t taken_px;
    pixel_t next_px;
    cell_t  got;
    cell_t  want;

    function automatic t_cell pack_nibbles(input pixel_t p);
        return {p.gate[PIX_W-1 -: NIB_W], p.uncert[PIX_W-1 -: NIB_W],
                p.range_inv[PIX_W-1 -: NIB_W], p.obstacle[PIX_W-1 -: NIB_W]};
    endfunction

    // max on the three lower nibbles, min on the gate nibble
    function automatic t_cell pool_join(input t_cell a, input t_cell b);
        t_cell           res;
        logic [NIB_W-1:0] na;
        logic [NIB_W-1:0] nb;
        for (int k = 0; k < 4; k++) begin
            na = a[k*NIB_W +: NIB_W];
            nb = b[k*NIB_W +: NIB_W];
            if (k < 3)
                res[k*NIB_W +: NIB_W] = (na > nb) ? na : nb;
            else
                res[k*NIB_W +: NIB_W] = (na < nb) ? na : nb;
        end
        return res;
    endfunction

    task automatic pool_pixel(input pixel_t p);
        t_cell px;
        t_cell pair;
        cell_t c;
        int    ocol;
        int    cell_no;
        px   = pack_nibbles(p);
        ocol = pix_col >> 1;
        if (pix_col % 2 == 0) begin
            pair_word = px;
        end else begin
            pair = pool_join(pair_word, px);
            if (pix_row % 2 == 0) begin
                line_store[ocol] = pair;
            end else begin
                cell_no = (pix_row >> 1) * OUT_W + ocol;
                c.word  = pool_join(line_store[ocol], pair);
                c.index = cell_no[IDX_W-1:0];
                c.last  = (cell_no == OUT_W * OUT_H - 1);
                cells_due.push_back(c);
                cells_expected++;
            end
        end
        if (pix_col + 1 >= IN_W) begin
            pix_col = 0;
            pix_row = (pix_row + 1 >= IN_H) ? 0 : pix_row + 1;
        end else begin
            pix_col++;
        end
    endtask

    task automatic note_fail(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%s", what);
    endtask

    function automatic logic [PIX_W-1:0] pick_byte();
        case ($urandom_range(0, 7))
            4:       return 8'h00;
            5:       return 8'hff;
            6:       return {4'hf, 4'($urandom)};
            7:       return {4'($urandom), 4'h0};
            default: return 8'($urandom);
        endcase
    endfunction

    // pixel driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left   <= 0;
            pixels_in  <= 0;
            px_taken   <= 1'b0;
            tail       <= 1'b0;
        end else begin
            px_taken <= i_in_valid && o_in_ready;
            taken_px <= '{i_obstacle, i_range_inverse, i_uncertainty, i_gate_opening};
            if (i_in_valid && o_in_ready)
                pixels_in <= pixels_in + 1;
            if (!i_in_valid || o_in_ready) begin
                if (gap_left != 0) begin
                    gap_left   <= gap_left - 1;
                    i_in_valid <= 1'b0;
                end else if (pixels_pending.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!tail && (pixels_in % 256) < 192 &&
                             $urandom_range(0, 3) == 0) begin
                    gap_left   <= $urandom_range(0, 4);
                    i_in_valid <= 1'b0;
                end else begin
                    next_px         = pixels_pending.pop_front();
                    i_in_valid      <= 1'b1;
                    i_obstacle      <= next_px.obstacle;
                    i_range_inverse <= next_px.range_inv;
                    i_uncertainty   <= next_px.uncert;
                    i_gate_opening  <= next_px.gate;
                end
            end
            tail <= pixels_pending.size() < TAIL_PIXELS;
        end
    end

    always @(negedge i_clk) begin
        if (px_taken)
            pool_pixel(taken_px);
    end

    // long receiver hold-off so the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && pixels_in >= HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // cell monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
            cells_seen  <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                cells_seen <= cells_seen + 1;
                got = '{o_cell_word, o_cell_index, o_last_cell};
                if (cells_due.size() == 0) begin
                    note_fail($sformatf("unexpected cell: word %h index %0d last %b",
                                        got.word, got.index, got.last));
                end else begin
                    want = cells_due.pop_front();
                    if (got.word !== want.word || got.index !== want.index ||
                        got.last !== want.last)
                        note_fail($sformatf(
                            "cell %0d: expected word %h index %0d last %b, got %h %0d %b",
                            cells_seen, want.word, want.index, want.last,
                            got.word, got.index, got.last));
                end
            end
            if (hold_left != 0) begin
                i_out_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left  <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else if (!tail && (cells_seen % 64) < 48 && $urandom_range(0, 3) == 0) begin
                stall_left  <= $urandom_range(0, 4);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles <= 0;
        end else if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("map_pool_2x2_nibble_pack_tb failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        pixel_t p;
        pix_col        = 0;
        pix_row        = 0;
        pair_word      = '0;
        cells_expected = 0;
        mismatches     = 0;
        for (int i = 0; i < OUT_W; i++)
            line_store[i] = '0;

        // frame start: extremes, crossed nibble patterns, per-channel highs and lows
        for (int i = 0; i < N_DIRECTED; i++) begin
            case (i % 6)
                0:       p = '{8'h00, 8'h00, 8'h00, 8'h00};
                1:       p = '{8'hff, 8'hff, 8'hff, 8'hff};
                2:       p = '{8'h0f, 8'hf0, 8'h0f, 8'hf0};
                3:       p = '{8'hf0, 8'h0f, 8'hf0, 8'h0f};
                4:       p = '{8'h80, 8'h7f, 8'h80, 8'h7f};
                default: p = '{8'h7f, 8'h80, 8'h7f, 8'h80};
            endcase
            pixels_pending.push_back(p);
        end
        for (int i = N_DIRECTED; i < N_PIXELS; i++) begin
            p = '{pick_byte(), pick_byte(), pick_byte(), pick_byte()};
            pixels_pending.push_back(p);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (!(pixels_in == N_PIXELS && cells_seen == cells_expected))
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (cells_due.size() != 0)
            note_fail($sformatf("%0d cells never arrived", cells_due.size()));

        if (mismatches == 0) begin
            $display("map_pool_2x2_nibble_pack_tb passed");
        end else begin
            $display("map_pool_2x2_nibble_pack_tb failed");
        end
        $finish;
    end
endmodule
